/* src/yaz0_pkg.sv */
// ----------------------------------------------------------------------------
// yaz0_pkg
// Shared constants, status codes and the command record passed from the
// stream parser to the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none
package yaz0_pkg;

  localparam int WINDOW_DEPTH     = 4096;
  localparam int WIN_AW           = $clog2(WINDOW_DEPTH);
  localparam int BYTES_PER_RESULT = 8;
  localparam int WORD_W           = 64;
  localparam int CNT_W            = 4;
  localparam int LEN_W            = 9;
  localparam int POS_W            = WIN_AW + 1;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
  localparam int HDR_IDX_W        = 4;

  localparam logic [31:0]        MAGIC_WORD     = 32'h59617A30;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX   = 4'd15;
  localparam logic [HDR_IDX_W-1:0] SIZE_FIRST_IDX = 4'd4;
  localparam logic [HDR_IDX_W-1:0] SIZE_LAST_IDX  = 4'd7;
  localparam logic [LEN_W-1:0]   LEN_SHORT_BIAS = 9'd2;
  localparam logic [LEN_W-1:0]   LEN_LONG_BIAS  = 9'h12;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_TRUNCATED  = 3'd2,
    ST_BAD_REF    = 3'd3,
    ST_LIMIT      = 3'd4
  } status_t;

  typedef struct packed {
    logic              literal;
    logic [7:0]        data;
    logic [WIN_AW-1:0] ref_dist;
    logic [LEN_W-1:0]  len;
    logic              fin;
    status_t           status;
    logic [31:0]       total;
  } cmd_t;

endpackage
`default_nettype wire

/* src/yaz0_ram.sv */
// ----------------------------------------------------------------------------
// yaz0_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module yaz0_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/yaz0_front.sv */
// ----------------------------------------------------------------------------
// yaz0_front
// Stream parser: header check, flag bytes, token decode and size tracking.
// Emits one command per input item that produces output or finishes.
// ----------------------------------------------------------------------------
`default_nettype none
module yaz0_front import yaz0_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic        queue_full,
  output logic             push,
  output cmd_t             cmd
);

  typedef enum logic [1:0] {PH_HEADER, PH_TOKEN, PH_REF2, PH_REF3} phase_t;

  logic [31:0]          max_size;
  logic [31:0]          expected;
  logic [31:0]          remaining;
  logic [POS_W-1:0]     pos_sat;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [7:0]           flags;
  logic [3:0]           flag_idx;
  phase_t               phase;
  logic [7:0]           ref1;
  logic [7:0]           ref2;
  logic                 finished;

  logic [31:0]          expected_next;
  logic [31:0]          remaining_next;
  logic [POS_W-1:0]     pos_sat_next;
  logic [HDR_IDX_W-1:0] hdr_idx_next;
  logic [7:0]           flags_next;
  logic [3:0]           flag_idx_next;
  phase_t               phase_next;
  logic [7:0]           ref1_next;
  logic [7:0]           ref2_next;
  logic                 fin;
  status_t              st;
  logic                 do_copy;
  logic                 do_lit;
  logic [LEN_W-1:0]     len_raw;
  logic [LEN_W-1:0]     n;
  logic [WIN_AW-1:0]    ref_dist;
  logic [POS_W:0]       pos_sum;
  logic [7:0]           magic_byte;
  logic                 accept;

  assign in_ready = finished || !queue_full;
  assign accept   = in_valid && in_ready && !finished;

  always_comb begin
    expected_next  = expected;
    remaining_next = remaining;
    pos_sat_next   = pos_sat;
    hdr_idx_next   = hdr_idx;
    flags_next     = flags;
    flag_idx_next  = flag_idx;
    phase_next     = phase;
    ref1_next      = ref1;
    ref2_next      = ref2;
    fin            = 1'b0;
    st             = ST_OK;
    do_copy        = 1'b0;
    do_lit         = 1'b0;
    len_raw        = '0;
    n              = '0;
    ref_dist       = {ref1[3:0], ref2};
    pos_sum        = '0;
    magic_byte     = MAGIC_WORD[8*(3 - 32'(hdr_idx[1:0])) +: 8];

    case (phase)
      PH_HEADER: begin
        if (hdr_idx < SIZE_FIRST_IDX) begin
          if (in_byte != magic_byte) begin
            fin = 1'b1;
            st  = ST_BAD_HEADER;
          end
        end else if (hdr_idx <= SIZE_LAST_IDX) begin
          expected_next = {expected[23:0], in_byte};
        end
        hdr_idx_next = hdr_idx + 1'b1;
        if (!fin && hdr_idx == HDR_LAST_IDX) begin
          if (expected > max_size) begin
            fin = 1'b1;
            st  = ST_LIMIT;
          end else if (expected == '0) begin
            fin = 1'b1;
          end else begin
            phase_next     = PH_TOKEN;
            remaining_next = expected;
          end
        end else if (!fin && in_last) begin
          fin = 1'b1;
          st  = ST_BAD_HEADER;
        end
      end
      PH_TOKEN: begin
        if (flag_idx == '0) begin
          flags_next    = in_byte;
          flag_idx_next = 4'd8;
        end else begin
          flags_next    = {flags[6:0], 1'b0};
          flag_idx_next = flag_idx - 1'b1;
          if (flags[7]) begin
            do_lit = 1'b1;
          end else begin
            ref1_next  = in_byte;
            phase_next = PH_REF2;
          end
        end
      end
      PH_REF2: begin
        ref2_next = in_byte;
        ref_dist  = {ref1[3:0], in_byte};
        if (ref1[7:4] == 4'd0) begin
          phase_next = PH_REF3;
        end else begin
          do_copy = 1'b1;
          len_raw = LEN_W'(ref1[7:4]) + LEN_SHORT_BIAS;
        end
      end
      default: begin
        do_copy = 1'b1;
        len_raw = LEN_W'(in_byte) + LEN_LONG_BIAS;
      end
    endcase

    if (do_lit) begin
      n = LEN_W'(1);
    end
    if (do_copy) begin
      phase_next = PH_TOKEN;
      if (POS_W'(ref_dist) >= pos_sat) begin
        fin = 1'b1;
        st  = ST_BAD_REF;
      end else if (32'(len_raw) > remaining) begin
        n = remaining[LEN_W-1:0];
      end else begin
        n = len_raw;
      end
    end
    if (do_lit || do_copy) begin
      remaining_next = remaining - 32'(n);
      pos_sum        = (POS_W+1)'(pos_sat) + (POS_W+1)'(n);
      pos_sat_next   = (pos_sum >= (POS_W+1)'(WINDOW_DEPTH)) ?
                       POS_W'(WINDOW_DEPTH) : pos_sum[POS_W-1:0];
    end
    if (!fin && phase != PH_HEADER && remaining_next == '0) begin
      fin = 1'b1;
    end
    if (!fin && in_last) begin
      fin = 1'b1;
      st  = ST_TRUNCATED;
    end

    cmd.literal  = do_lit;
    cmd.data     = in_byte;
    cmd.ref_dist = ref_dist;
    cmd.len      = n;
    cmd.fin      = fin;
    cmd.status   = st;
    cmd.total    = (fin && st == ST_OK) ? expected_next : '0;
    push         = accept && (n != '0 || fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size  <= '1;
      expected  <= '0;
      remaining <= '0;
      pos_sat   <= '0;
      hdr_idx   <= '0;
      flags     <= '0;
      flag_idx  <= '0;
      phase     <= PH_HEADER;
      ref1      <= '0;
      ref2      <= '0;
      finished  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_size <= cfg_wdata;
      end
      if (accept) begin
        expected  <= expected_next;
        remaining <= remaining_next;
        pos_sat   <= pos_sat_next;
        hdr_idx   <= hdr_idx_next;
        flags     <= flags_next;
        flag_idx  <= flag_idx_next;
        phase     <= phase_next;
        ref1      <= ref1_next;
        ref2      <= ref2_next;
        finished  <= fin;
      end
    end
  end

endmodule
`default_nettype wire

/* src/yaz0_queue.sv */
// ----------------------------------------------------------------------------
// yaz0_queue
// Short command queue between parser and copy engine.
// ----------------------------------------------------------------------------
`default_nettype none
module yaz0_queue import yaz0_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      not_empty
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/yaz0_back.sv */
// ----------------------------------------------------------------------------
// yaz0_back
// Copy engine: writes literals and back-reference bytes into the history
// window and packs each command's bytes into result words.
// ----------------------------------------------------------------------------
`default_nettype none
module yaz0_back import yaz0_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  cmd_t                    cmd,
  output logic                    pop,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic [WORD_W-1:0]       res_bytes,
  output logic [CNT_W-1:0]        res_count,
  output status_t                 res_status,
  output logic                    res_done,
  output logic [31:0]             res_total,
  output logic                    res_last
);

  typedef enum logic [1:0] {B_IDLE, B_READ, B_DATA, B_SEND} bstate_t;

  bstate_t           state;
  logic [WIN_AW-1:0] wpos;
  logic [WIN_AW-1:0] ref_dist;
  logic [LEN_W-1:0]  left;
  logic [WORD_W-1:0] word;
  logic [CNT_W-1:0]  cnt;
  logic              fin;
  status_t           status;
  logic [31:0]       total;

  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [WIN_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              can_load;

  assign pop       = state == B_IDLE && cmd_valid;
  assign ram_we    = (pop && cmd.literal) || state == B_DATA;
  assign ram_wdata = (state == B_DATA) ? ram_rdata : cmd.data;
  assign ram_raddr = wpos - ref_dist - 1'b1;
  assign can_load  = !res_valid || res_ready;

  yaz0_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wpos      <= '0;
      res_valid <= 1'b0;
      left      <= '0;
      word      <= '0;
      cnt       <= '0;
    end else begin
      if (res_valid && res_ready && state != B_SEND) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            ref_dist <= cmd.ref_dist;
            fin      <= cmd.fin;
            status   <= cmd.status;
            total    <= cmd.total;
            if (cmd.literal) begin
              word  <= {{(WORD_W-8){1'b0}}, cmd.data};
              cnt   <= CNT_W'(1);
              left  <= '0;
              wpos  <= wpos + 1'b1;
              state <= B_SEND;
            end else if (cmd.len == '0) begin
              word  <= '0;
              cnt   <= '0;
              left  <= '0;
              state <= B_SEND;
            end else begin
              word  <= '0;
              cnt   <= '0;
              left  <= cmd.len;
              state <= B_READ;
            end
          end
        end
        B_READ: begin
          state <= B_DATA;
        end
        B_DATA: begin
          word[8*cnt[2:0] +: 8] <= ram_rdata;
          cnt  <= cnt + 1'b1;
          left <= left - 1'b1;
          wpos <= wpos + 1'b1;
          if (left == LEN_W'(1) || cnt == CNT_W'(BYTES_PER_RESULT - 1)) begin
            state <= B_SEND;
          end else begin
            state <= B_READ;
          end
        end
        B_SEND: begin
          if (can_load) begin
            res_valid  <= 1'b1;
            res_bytes  <= word;
            res_count  <= cnt;
            res_last   <= left == '0;
            res_done   <= left == '0 && fin;
            res_status <= (left == '0 && fin) ? status : ST_OK;
            res_total  <= (left == '0 && fin) ? total : '0;
            word       <= '0;
            cnt        <= '0;
            state      <= (left == '0) ? B_IDLE : B_READ;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/yaz0_stream_decompressor.sv */
// ----------------------------------------------------------------------------
// yaz0_stream_decompressor
// Yaz0 decoder: byte stream in, packed decoded bytes plus status out.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tdata[7:0] in_byte, tlast in_last
//   m_axis    out  m_axis_tvalid/tready       tdata out_bytes..total_size, tlast
//   cfg       in   cfg_we                     cfg_wdata max_output_size
//
// Header, flag and reference-prefix bytes are decoded in the parser.
// A literal passes through the idle and send states of the copy engine; a
// back-reference takes its command in the idle state, copies each byte through
// the read and data states (registered history RAM read) and sends each result
// from the send state. Each result waits while the output item is not taken.
// The four-entry command queue stalls input while the engine catches up.
// Synchronous active-high reset; history contents are not cleared.
`default_nettype none
module yaz0_stream_decompressor import yaz0_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // in_byte[7:0]
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,   // out_bytes, byte_count, status,
                                            // done_res, total_size
  output logic              m_axis_tlast
);

  logic               push;
  cmd_t               push_cmd;
  logic               full;
  logic               pop;
  cmd_t               head;
  logic               not_empty;
  logic [WORD_W-1:0]  res_bytes;
  logic [CNT_W-1:0]   res_count;
  status_t            res_status;
  logic               res_done;
  logic [31:0]        res_total;

  yaz0_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  yaz0_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  yaz0_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (not_empty),
    .cmd        (head),
    .pop        (pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_bytes  (res_bytes),
    .res_count  (res_count),
    .res_status (res_status),
    .res_done   (res_done),
    .res_total  (res_total),
    .res_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {res_total, res_done, res_status, res_count, res_bytes};

`ifndef SYNTHESIS
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[71] |-> m_axis_tlast)
    else $error("done without last");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[67:64] <= 4'd8)
    else $error("byte count out of range");

  a_total_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[103:72] != 32'd0 |->
      m_axis_tdata[71] && m_axis_tdata[70:68] == 3'd0)
    else $error("total size without clean finish");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command pushed into full queue");
`endif

endmodule
`default_nettype wire
